>>> rtl/tagged_bitmap_chunk_allocator_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the tagged bitmap chunk allocator
// Shared property wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TAGGED_BITMAP_CHUNK_ALLOCATOR_ASSERT_SVH
`define TAGGED_BITMAP_CHUNK_ALLOCATOR_ASSERT_SVH

// same-cycle implication
`define TBCA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TBCA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tbca_pkg.sv
// ----------------------------------------------------------------------------
// tbca_pkg
// Types and constants shared by the chunk allocator modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package tbca_pkg;

  localparam int DEF_MAX_CHUNKS = 4096;
  localparam int MAX_ALIGN      = 4096;
  localparam int MAX_LOG2       = 12;
  localparam int NEED_W         = 21;

  localparam logic [1:0] REG_CHUNK_LOG2 = 2'd0;
  localparam logic [1:0] REG_CHUNKS     = 2'd1;
  localparam logic [1:0] REG_BASE       = 2'd2;
  localparam logic [1:0] REG_MAX_REQ    = 2'd3;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_SIZE  = 3'd1,
    ST_BAD_ALIGN = 3'd2,
    ST_NO_MEM    = 3'd3,
    ST_DBL_FREE  = 3'd4,
    ST_OUTSIDE   = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_CHK, S_ARD, S_AWT, S_LRD, S_LWT,
    S_RRD, S_RWT, S_AWR, S_FRD, S_FWT, S_DONE
  } state_t;

  typedef struct packed {
    logic [3:0]  chunk_size_log2;
    logic [12:0] chunks_in_use;
    logic [31:0] base_address;
    logic [20:0] max_request_bytes;
  } cfg_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  // smallest id in 1..3 differing from both neighbors
  function automatic logic [1:0] pick_id(input logic [1:0] l, input logic [1:0] r);
    logic [1:0] id;
    id = 2'd1;
    if (l == 2'd1 || r == 2'd1) begin
      id = (l == 2'd2 || r == 2'd2) ? 2'd3 : 2'd2;
    end
    return id;
  endfunction

endpackage

>>> rtl/tbca_tag_mem.sv
// ----------------------------------------------------------------------------
// tbca_tag_mem
// Tag store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tbca_tag_mem import tbca_pkg::*; #(
  parameter int MAX_CHUNKS = DEF_MAX_CHUNKS,
  localparam int AW = $clog2(MAX_CHUNKS)
) (
  input  logic          clk,
  input  mem_ctl_t      ctl,
  input  logic [AW-1:0] rd_addr,
  input  logic [AW-1:0] wr_addr,
  input  logic [1:0]    wr_data,
  output logic [1:0]    rd_data
);

  logic [1:0] tags [MAX_CHUNKS];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      tags[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= tags[rd_addr];
    end
  end

endmodule

>>> rtl/tbca_engine.sv
// ----------------------------------------------------------------------------
// tbca_engine
// Sequencer: clear pass, first-fit scan, run tagging and run freeing.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tbca_engine import tbca_pkg::*; #(
  parameter int MAX_CHUNKS = DEF_MAX_CHUNKS,
  localparam int AW = $clog2(MAX_CHUNKS),
  localparam int CW = AW + 1,
  localparam int IW = (AW + 2 > 14) ? AW + 2 : 14
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  input  logic          geom_wr,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          in_action,
  input  logic [20:0]   in_size,
  input  logic [15:0]   in_align,
  input  logic [31:0]   in_address,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [2:0]    out_status,
  output logic [31:0]   out_address,
  output logic [12:0]   out_free,
  output mem_ctl_t      mctl,
  output logic [AW-1:0] rd_addr,
  output logic [AW-1:0] wr_addr,
  output logic [1:0]    wr_data,
  input  logic [1:0]    rd_data
);

  state_t state, state_next;
  logic [AW-1:0] ccnt, ccnt_next;
  logic act;
  logic [20:0] size;
  logic [15:0] align;
  logic [31:0] address;
  logic [NEED_W-1:0] need, need_next, cnt, cnt_next;
  logic [IW-1:0] off, off_next, step, step_next, idx, idx_next, at, at_next;
  logic [1:0] left, left_next, id, id_next;
  logic first, first_next;
  logic [CW-1:0] freec, freec_next;
  status_t status, status_next;
  logic [31:0] raddr, raddr_next;
  logic out_valid_next;
  logic [2:0] out_status_next;
  logic [31:0] out_address_next;
  logic [12:0] out_free_next;

  // effective geometry
  logic [3:0] lg;
  logic [CW-1:0] n;
  logic [IW-1:0] n_i;
  logic [12:0] cs;
  logic [32:0] heap_end;
  logic [31:0] rel;
  logic [IW-1:0] mask, jump;
  logic [21:0] run_end;
  logic [16:0] pow_chk;
  logic [12:0] rem;

  assign lg = (cfg.chunk_size_log2 > 4'(MAX_LOG2)) ? 4'(MAX_LOG2) : cfg.chunk_size_log2;
  assign n = (32'(cfg.chunks_in_use) > 32'(MAX_CHUNKS)) ? CW'(MAX_CHUNKS)
                                                       : CW'(cfg.chunks_in_use);
  assign n_i = IW'(n);
  assign cs = 13'd1 << lg;
  assign heap_end = {1'b0, cfg.base_address} + (33'(n) << lg);
  assign rel = address - cfg.base_address;
  assign mask = ~(step - IW'(1));
  assign jump = ((idx - off + step) & mask) + off;
  assign run_end = 22'(at) + 22'(need);
  assign pow_chk = 17'(align) & (17'(align) - 17'd1);
  assign rem = 13'(cfg.base_address[15:0] & (align - 16'd1));

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      act     <= in_action;
      size    <= in_size;
      align   <= in_align;
      address <= in_address;
    end
    need  <= need_next;
    cnt   <= cnt_next;
    off   <= off_next;
    step  <= step_next;
    idx   <= idx_next;
    at    <= at_next;
    left  <= left_next;
    id    <= id_next;
    first <= first_next;
    status <= status_next;
    raddr <= raddr_next;
    out_status  <= out_status_next;
    out_address <= out_address_next;
    out_free    <= out_free_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      ccnt      <= '0;
      freec     <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      ccnt      <= ccnt_next;
      freec     <= freec_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    ccnt_next = ccnt;
    need_next = need;
    cnt_next = cnt;
    off_next = off;
    step_next = step;
    idx_next = idx;
    at_next = at;
    left_next = left;
    id_next = id;
    first_next = first;
    freec_next = freec;
    status_next = status;
    raddr_next = raddr;
    out_valid_next = out_valid && !out_ready;
    out_status_next = out_status;
    out_address_next = out_address;
    out_free_next = out_free;
    mctl = '0;
    rd_addr = idx[AW-1:0];
    wr_addr = idx[AW-1:0];
    wr_data = 2'd0;
    in_ready = 1'b0;

    case (state)
      S_CLR: begin
        mctl.wr_en = 1'b1;
        wr_addr = ccnt;
        ccnt_next = ccnt + AW'(1);
        if (ccnt == AW'(MAX_CHUNKS - 1)) begin
          freec_next = n;
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = S_CHK;
        end
      end
      S_CHK: begin
        raddr_next = '0;
        status_next = ST_OK;
        state_next = S_DONE;
        if (!act) begin
          if (size == '0 || size > cfg.max_request_bytes) begin
            status_next = ST_BAD_SIZE;
          end else if (align == '0 || pow_chk != '0 || align > 16'(MAX_ALIGN)) begin
            status_next = ST_BAD_ALIGN;
          end else begin
            need_next = NEED_W'(1) + ((size - 21'd1) >> lg);
            off_next = '0;
            step_next = IW'(1);
            if (17'(align) > 17'(cs)) begin
              if (rem != '0) begin
                off_next = IW'((13'(align) - rem) >> lg);
              end
              step_next = IW'(align >> lg);
            end
            idx_next = '0;
            cnt_next = '0;
            state_next = S_ARD;
          end
        end else if (address != '0) begin
          if (address < cfg.base_address || {1'b0, address} >= heap_end) begin
            status_next = ST_OUTSIDE;
          end else begin
            idx_next = IW'(rel >> lg);
            first_next = 1'b1;
            state_next = S_FRD;
          end
        end
      end
      S_ARD: begin
        // first visit starts at the offset
        if (cnt == '0 && idx == '0) begin
          idx_next = off;
        end
        if ((cnt == '0 && idx == '0 ? off : idx) >= n_i) begin
          status_next = ST_NO_MEM;
          raddr_next = '0;
          state_next = S_DONE;
        end else begin
          mctl.rd_en = 1'b1;
          rd_addr = (cnt == '0 && idx == '0) ? off[AW-1:0] : idx[AW-1:0];
          state_next = S_AWT;
        end
      end
      S_AWT: begin
        if (rd_data == 2'd0) begin
          cnt_next = cnt + NEED_W'(1);
          if (cnt == '0) begin
            at_next = idx;
          end
          if (cnt + NEED_W'(1) == need) begin
            state_next = S_LRD;
          end else begin
            idx_next = idx + IW'(1);
            state_next = S_ARD;
          end
        end else begin
          cnt_next = '0;
          idx_next = (step > IW'(1)) ? jump : idx + IW'(1);
          state_next = S_ARD;
        end
        // keep the start-of-scan marker from re-firing at chunk zero
        if (idx_next == '0) begin
          cnt_next = (rd_data == 2'd0) ? cnt + NEED_W'(1) : cnt;
        end
      end
      S_LRD: begin
        if (at != '0) begin
          mctl.rd_en = 1'b1;
          rd_addr = AW'(at - IW'(1));
          state_next = S_LWT;
        end else begin
          left_next = 2'd0;
          state_next = S_RRD;
        end
      end
      S_LWT: begin
        left_next = rd_data;
        state_next = S_RRD;
      end
      S_RRD: begin
        idx_next = at;
        cnt_next = '0;
        if (run_end < 22'(n)) begin
          mctl.rd_en = 1'b1;
          rd_addr = run_end[AW-1:0];
          state_next = S_RWT;
        end else begin
          id_next = pick_id(left, 2'd0);
          state_next = S_AWR;
        end
      end
      S_RWT: begin
        id_next = pick_id(left, rd_data);
        state_next = S_AWR;
      end
      S_AWR: begin
        mctl.wr_en = 1'b1;
        wr_data = id;
        idx_next = idx + IW'(1);
        cnt_next = cnt + NEED_W'(1);
        if (cnt + NEED_W'(1) == need) begin
          freec_next = freec - CW'(need);
          raddr_next = cfg.base_address + (32'(at) << lg);
          status_next = ST_OK;
          state_next = S_DONE;
        end
      end
      S_FRD: begin
        if (idx < n_i) begin
          mctl.rd_en = 1'b1;
          state_next = S_FWT;
        end else begin
          state_next = S_DONE;
        end
      end
      S_FWT: begin
        if (first && rd_data == 2'd0) begin
          status_next = ST_DBL_FREE;
          state_next = S_DONE;
        end else if (first || rd_data == id) begin
          if (first) begin
            id_next = rd_data;
          end
          first_next = 1'b0;
          mctl.wr_en = 1'b1;
          wr_data = 2'd0;
          freec_next = freec + CW'(1);
          idx_next = idx + IW'(1);
          state_next = S_FRD;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_valid_next = 1'b1;
          out_status_next = status;
          out_address_next = raddr;
          out_free_next = 13'(freec);
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase

    if (geom_wr) begin
      state_next = S_CLR;
      ccnt_next = '0;
    end
  end

`include "tagged_bitmap_chunk_allocator_assert.svh"

  `TBCA_ASSERT_NOW(a_no_write_idle, mctl.wr_en, !in_ready, "tag write while idle")
  `TBCA_ASSERT_NOW(a_free_bound, state == S_IDLE && !geom_wr, freec <= n, "free count over heap")
  `TBCA_ASSERT_NEXT(a_out_from_done, !out_valid && state != S_DONE, !out_valid,
                    "result without completion")

endmodule

>>> rtl/tagged_bitmap_chunk_allocator.sv
// ----------------------------------------------------------------------------
// tagged_bitmap_chunk_allocator
// Chunk heap allocator with 2-bit run tags kept in a synchronous tag store.
//
//   port group   dir  role
//   s_axis_*     in   request words (allocate / free)
//   m_axis_*     out  response words, one per request
//   p*           in   register access, four 32-bit registers
//
// Every request passes through accept, check and completion. An allocate
// adds a tag read, waiting on the registered read data, for each chunk the
// first-fit scan visits, neighbor tag reads and a tag write per chunk
// tagged; a free reads and clears each chunk of the run in turn, ending on
// another tag or at the heap end. Rejected and null requests go from the
// check straight to completion. Reset and any write to chunk_size_log2,
// chunks_in_use or base_address run a clearing pass over all MAX_CHUNKS tag
// entries; requests are held off meanwhile. A stalled response holds in the
// output register; the next request is taken and waits only at completion.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tagged_bitmap_chunk_allocator import tbca_pkg::*; #(
  parameter int MAX_CHUNKS = DEF_MAX_CHUNKS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // size_bytes[20:0], alignment[36:21], address[68:37]
  input  logic [0:0]  s_axis_tuser,  // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,  // status[2:0], result_address[34:3], free_left[47:35]
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int AW = $clog2(MAX_CHUNKS);

  cfg_t cfg;
  logic cfg_wr, geom_wr;
  logic [1:0] reg_idx;
  mem_ctl_t mctl;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [1:0] wr_data, rd_data;
  logic [2:0] out_status;
  logic [31:0] out_address;
  logic [12:0] out_free;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  // geometry writes wipe the heap
  assign geom_wr = cfg_wr && (reg_idx != REG_MAX_REQ);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.chunk_size_log2   <= 4'd4;
      cfg.chunks_in_use     <= 13'd4096;
      cfg.base_address      <= '0;
      cfg.max_request_bytes <= 21'd65536;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_CHUNK_LOG2: cfg.chunk_size_log2   <= pwdata[3:0];
        REG_CHUNKS:     cfg.chunks_in_use     <= pwdata[12:0];
        REG_BASE:       cfg.base_address      <= pwdata;
        REG_MAX_REQ:    cfg.max_request_bytes <= pwdata[20:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CHUNK_LOG2: prdata = 32'(cfg.chunk_size_log2);
      REG_CHUNKS:     prdata = 32'(cfg.chunks_in_use);
      REG_BASE:       prdata = cfg.base_address;
      REG_MAX_REQ:    prdata = 32'(cfg.max_request_bytes);
      default:        prdata = '0;
    endcase
  end

  tbca_engine #(.MAX_CHUNKS(MAX_CHUNKS)) u_engine (
    .clk, .rst, .cfg, .geom_wr,
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_action  (s_axis_tuser[0]),
    .in_size    (s_axis_tdata[20:0]),
    .in_align   (s_axis_tdata[36:21]),
    .in_address (s_axis_tdata[68:37]),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_status, .out_address, .out_free,
    .mctl, .rd_addr, .wr_addr, .wr_data, .rd_data
  );

  tbca_tag_mem #(.MAX_CHUNKS(MAX_CHUNKS)) u_tags (
    .clk, .ctl(mctl), .rd_addr, .wr_addr, .wr_data, .rd_data
  );

  assign m_axis_tdata = {out_free, out_address, out_status};

endmodule
